>>> src/deformable_trilinear_tap_backward_defines.svh
// assertion macros shared by the deformable trilinear tap backward rtl
`ifndef DEFORMABLE_TRILINEAR_TAP_BACKWARD_DEFINES_SVH
`define DEFORMABLE_TRILINEAR_TAP_BACKWARD_DEFINES_SVH

// checked on every rising edge outside reset
`define DTB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge including reset
`define DTB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/dtb_pkg.sv
// shared types, constants and arithmetic helpers of the trilinear tap backward block
`default_nettype none

package dtb_pkg;

  localparam int MAX_VOLUME_DEF = 32768;
  localparam int MAX_DIM_DEF    = 32;

  // extended address domain, wide enough for any corner address and volume size
  localparam int XW     = 21;
  // interpolated value and per-axis difference accumulators
  localparam int VAL_W  = 42;
  localparam int DIFF_W = 36;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TAP  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_LENGTH = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_WIDTH  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ACC_ADD      = 1'b0,
    ACC_CLR_READ = 1'b1
  } acc_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_RDATA,
    S_RANGE,
    S_ADDR,
    S_CHECK,
    S_CORNER,
    S_DRAIN,
    S_ACCUM,
    S_FIN1,
    S_FIN2,
    S_EMIT
  } state_e;

  // one corner sample request with its three axis weights
  typedef struct packed {
    logic       vld;
    logic [2:0] idx;
    logic [8:0] wl;
    logic [8:0] wh;
    logic [8:0] ww;
  } corner_req_t;

  // accumulator access request
  typedef struct packed {
    logic       vld;
    acc_kind_e  kind;
    logic [2:0] idx;
  } acc_req_t;

  // scatter contribution of one corner
  typedef struct packed {
    logic              vld;
    logic [2:0]        idx;
    logic signed [31:0] value;
  } add_beat_t;

  // effective dimension, capped at the largest supported extent
  function automatic logic [5:0] eff_dim(input logic [5:0] r, input int max_dim);
    logic [5:0] d;
    d = r;
    if (int'(r) > max_dim) begin
      d = 6'(max_dim);
    end
    return d;
  endfunction

  // round half up by a constant shift, then saturate to 32 bits
  function automatic logic signed [31:0] rnd_sat(input logic signed [67:0] x,
                                                 input logic [4:0] sh);
    logic signed [67:0] y;
    logic signed [31:0] r;
    y = (x + (68'sd1 <<< (sh - 5'd1))) >>> sh;
    r = y[31:0];
    if (y > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (y < -68'sd2147483648) begin
      r = 32'sh80000000;
    end
    return r;
  endfunction

  // 32-bit add with saturation
  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = {a[31], a} + {b[31], b};
    r = s[31:0];
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh80000000 : 32'sh7fffffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/dtb_sample_unit.sv
// input volume memory and the per-corner interpolation pipeline
`default_nettype none

module dtb_sample_unit #(
  parameter int MAX_VOLUME = dtb_pkg::MAX_VOLUME_DEF,
  localparam int AW = $clog2(MAX_VOLUME)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic signed [15:0]                wr_data_i,
  input  dtb_pkg::corner_req_t              req_i,
  input  logic [AW-1:0]                     rd_addr_i,
  input  logic signed [31:0]                fr_prod_i,
  output logic signed [dtb_pkg::VAL_W-1:0]  val_o,
  output logic signed [dtb_pkg::DIFF_W-1:0] diff_l_o,
  output logic signed [dtb_pkg::DIFF_W-1:0] diff_h_o,
  output logic signed [dtb_pkg::DIFF_W-1:0] diff_w_o,
  output dtb_pkg::add_beat_t                add_o
);

  logic signed [15:0] mem_q [MAX_VOLUME];
  logic signed [15:0] rdata_q;

  logic        s1_vld_q, s2_vld_q, s3_vld_q;
  logic [2:0]  s1_idx_q, s2_idx_q, s3_idx_q;
  logic [16:0] s1_wlh_q, s1_wlw_q, s1_whw_q;
  logic [8:0]  s1_ww_q;
  logic signed [15:0] s2_c_q;
  logic [24:0] s2_wgt_q;
  logic signed [33:0] s2_pl_q, s2_ph_q, s2_pw_q;
  logic signed [57:0] s3_prod_q;
  logic signed [dtb_pkg::VAL_W-1:0]  val_q;
  logic signed [dtb_pkg::DIFF_W-1:0] dl_q, dh_q, dw_q;

  logic [17:0] wlh, wlw, whw;
  logic [25:0] wgt_full;
  logic signed [33:0] pl, ph, pw;
  logic signed [dtb_pkg::VAL_W-1:0] cw;
  logic signed [57:0] prod;
  logic signed [57:0] rnd;

  // sample memory, one write and one read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (req_i.vld) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // two-axis weight products
  assign wlh = req_i.wl * req_i.wh;
  assign wlw = req_i.wl * req_i.ww;
  assign whw = req_i.wh * req_i.ww;

  // corner weight and sample-weighted partial differences
  assign wgt_full = s1_wlh_q * s1_ww_q;
  assign pl = $signed(rdata_q) * $signed({1'b0, s1_whw_q});
  assign ph = $signed(rdata_q) * $signed({1'b0, s1_wlw_q});
  assign pw = $signed(rdata_q) * $signed({1'b0, s1_wlh_q});

  // interpolation term and scatter product
  assign cw   = $signed(s2_c_q) * $signed({1'b0, s2_wgt_q});
  assign prod = fr_prod_i * $signed({1'b0, s2_wgt_q});

  // round the scatter product from q34.24 to an integer
  assign rnd = (s3_prod_q + 58'sh800000) >>> 24;

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= req_i.vld;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // pipeline payload and accumulators, first corner restarts the sums
  always_ff @(posedge clk_i) begin
    s1_idx_q  <= req_i.idx;
    s1_wlh_q  <= wlh[16:0];
    s1_wlw_q  <= wlw[16:0];
    s1_whw_q  <= whw[16:0];
    s1_ww_q   <= req_i.ww;
    s2_idx_q  <= s1_idx_q;
    s2_c_q    <= rdata_q;
    s2_wgt_q  <= wgt_full[24:0];
    s2_pl_q   <= pl;
    s2_ph_q   <= ph;
    s2_pw_q   <= pw;
    s3_idx_q  <= s2_idx_q;
    s3_prod_q <= prod;
    if (s2_vld_q) begin
      if (s2_idx_q == 3'd0) begin
        val_q <= cw;
        dl_q  <= -DIFF_W'(s2_pl_q);
        dh_q  <= -DIFF_W'(s2_ph_q);
        dw_q  <= -DIFF_W'(s2_pw_q);
      end else begin
        val_q <= val_q + cw;
        dl_q  <= s2_idx_q[2] ? dl_q + DIFF_W'(s2_pl_q) : dl_q - DIFF_W'(s2_pl_q);
        dh_q  <= s2_idx_q[1] ? dh_q + DIFF_W'(s2_ph_q) : dh_q - DIFF_W'(s2_ph_q);
        dw_q  <= s2_idx_q[0] ? dw_q + DIFF_W'(s2_pw_q) : dw_q - DIFF_W'(s2_pw_q);
      end
    end
  end

  localparam int DIFF_W = dtb_pkg::DIFF_W;

  assign val_o       = val_q;
  assign diff_l_o    = dl_q;
  assign diff_h_o    = dh_q;
  assign diff_w_o    = dw_q;
  assign add_o.vld   = s3_vld_q;
  assign add_o.idx   = s3_idx_q;
  assign add_o.value = rnd[31:0];

endmodule

`default_nettype wire

>>> src/dtb_accum_unit.sv
// gradient accumulator memory with clear sweep, read-modify-write and readout
`default_nettype none

module dtb_accum_unit #(
  parameter int MAX_VOLUME = dtb_pkg::MAX_VOLUME_DEF,
  localparam int AW = $clog2(MAX_VOLUME)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtb_pkg::acc_req_t  req_i,
  input  logic [AW-1:0]      addr_i,
  input  dtb_pkg::add_beat_t add_i,
  output logic               clearing_o,
  output logic signed [31:0] rdata_o
);

  `include "deformable_trilinear_tap_backward_defines.svh"

  logic signed [31:0] mem_q [MAX_VOLUME];
  logic signed [31:0] rd_q;
  logic signed [31:0] adds_q [8];

  logic               clearing_q;
  logic [AW-1:0]      clr_cnt_q;
  logic               s1_vld_q;
  dtb_pkg::acc_kind_e s1_kind_q;
  logic [2:0]         s1_idx_q;
  logic [AW-1:0]      s1_addr_q;
  logic               pw_vld_q;
  logic [AW-1:0]      pw_addr_q;
  logic signed [31:0] pw_data_q;

  logic signed [31:0] old_val;
  logic signed [31:0] upd;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  // clear sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      if (clr_cnt_q == AW'(MAX_VOLUME - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // request and last-write valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      pw_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= req_i.vld;
      pw_vld_q <= s1_vld_q;
    end
  end

  // request payload, last write and per-corner contributions
  always_ff @(posedge clk_i) begin
    s1_kind_q <= req_i.kind;
    s1_idx_q  <= req_i.idx;
    s1_addr_q <= addr_i;
    pw_addr_q <= s1_addr_q;
    pw_data_q <= upd;
    if (add_i.vld) begin
      adds_q[add_i.idx] <= add_i.value;
    end
  end

  // accumulator memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (req_i.vld) begin
      rd_q <= mem_q[addr_i];
    end
  end

  // forward the write of the previous beat to the same entry
  assign old_val = (pw_vld_q && pw_addr_q == s1_addr_q) ? pw_data_q : rd_q;

  // modify
  always_comb begin
    case (s1_kind_q)
      dtb_pkg::ACC_ADD:      upd = dtb_pkg::sat_add32(old_val, adds_q[s1_idx_q]);
      dtb_pkg::ACC_CLR_READ: upd = '0;
      default:               upd = '0;
    endcase
  end

  // write back, the clear sweep has the port while it runs
  assign wr_en   = clearing_q | s1_vld_q;
  assign wr_addr = clearing_q ? clr_cnt_q : s1_addr_q;
  assign wr_data = clearing_q ? 32'sd0 : upd;

  assign clearing_o = clearing_q;
  assign rdata_o    = old_val;

  `DTB_ASSERT(a_no_req_in_clear, clearing_q |-> !req_i.vld, "access during clear sweep")
  `DTB_ASSERT(a_clear_once, !clearing_q |=> !clearing_q, "clear sweep restarted")
  `DTB_ASSERT(a_clear_end, $fell(clearing_q) |-> $past(clr_cnt_q) == AW'(MAX_VOLUME - 1), "clear sweep ended early")

endmodule

`default_nettype wire

>>> src/deformable_trilinear_tap_backward.sv
// tap sequencer: one tap reads 8 corner samples, then read-modify-writes 8 accumulators
// no new start is taken while busy; one is taken at the earliest in the cycle the last result shows
// the tap is paced by 8 corner reads plus 8 accumulator read-modify-writes on one port
// reset: config back to 32, accumulator cleared by a sweep over all MAX_VOLUME entries, busy high
// done_o is high for one cycle, the result holds on the ports until the next start, the receiver cannot stall
`default_nettype none

module deformable_trilinear_tap_backward #(
  parameter int MAX_VOLUME = dtb_pkg::MAX_VOLUME_DEF,
  parameter int MAX_DIM    = dtb_pkg::MAX_DIM_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  input  logic [1:0]         opcode_i,
  input  logic [14:0]        address_i,
  input  logic signed [15:0] sample_value_i,
  input  logic signed [6:0]  base_l_i,
  input  logic signed [6:0]  base_h_i,
  input  logic signed [6:0]  base_w_i,
  input  logic signed [15:0] offset_l_i,
  input  logic signed [15:0] offset_h_i,
  input  logic signed [15:0] offset_w_i,
  input  logic signed [15:0] filter_weight_i,
  input  logic signed [15:0] residual_i,
  output logic               in_range_o,
  output logic signed [31:0] filter_grad_o,
  output logic signed [31:0] offset_grad_l_o,
  output logic signed [31:0] offset_grad_h_o,
  output logic signed [31:0] offset_grad_w_o,
  output logic signed [31:0] read_data_o
);

  `include "deformable_trilinear_tap_backward_defines.svh"

  localparam int AW = $clog2(MAX_VOLUME);
  localparam int XW = dtb_pkg::XW;

  dtb_pkg::state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [5:0]  dim_q [3];
  logic [5:0]  dim_e [3];

  logic [XW-1:0]      addr_q;
  logic               rd_ok_q;
  logic signed [16:0] pos_q [3];
  logic signed [15:0] fw_q, r_q;
  logic signed [31:0] frp_q;
  logic [5:0]         lo_q [3];
  logic [7:0]         frac_q [3];
  logic               ok_q;
  logic [11:0]        hw_q;
  logic [XW-1:0]      alo_q;
  logic [11:0]        stl_q;
  logic [5:0]         sth_q;
  logic               stw_q;
  logic signed [57:0] fgp_q;
  logic signed [67:0] ogp_q [3];

  logic               in_range_q;
  logic signed [31:0] fg_q, ogl_q, ogh_q, ogw_q, rdat_q;

  logic               accept;
  logic [XW-1:0]      addr_x;
  logic               addr_ok;
  logic [XW-1:0]      corner_addr;
  logic [XW-1:0]      last_addr;
  logic [XW-1:0]      alo_d;
  logic               ok_d;
  logic [15:0]        lim [3];
  logic [8:0]         w_sel [3];

  logic                  ld_we;
  dtb_pkg::corner_req_t  smp_req;
  dtb_pkg::acc_req_t     acc_req;
  logic [AW-1:0]         acc_addr;
  dtb_pkg::add_beat_t    add_beat;
  logic                  clearing;
  logic signed [31:0]    acc_rdata;
  logic signed [dtb_pkg::VAL_W-1:0]  val;
  logic signed [dtb_pkg::DIFF_W-1:0] diff_l, diff_h, diff_w;

  assign accept      = start && !busy;
  assign busy        = clearing || (state_q != dtb_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign addr_x      = XW'(address_i);
  assign addr_ok     = addr_x < XW'(MAX_VOLUME);

  // effective dimensions
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dim_e[a] = dtb_pkg::eff_dim(dim_q[a], MAX_DIM);
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q[0] <= 6'd32;
      dim_q[1] <= 6'd32;
      dim_q[2] <= 6'd32;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dtb_pkg::cfg_reg_e'(cfg_index_i))
        dtb_pkg::REG_LENGTH: dim_q[0] <= cfg_data_i;
        dtb_pkg::REG_HEIGHT: dim_q[1] <= cfg_data_i;
        dtb_pkg::REG_WIDTH:  dim_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-axis range check
  always_comb begin
    ok_d = 1'b1;
    for (int a = 0; a < 3; a++) begin
      lim[a] = {2'b00, dim_e[a] - 6'd1, 8'd0};
      if (dim_e[a] == 6'd0 || pos_q[a][16] || pos_q[a][15:0] > lim[a]) begin
        ok_d = 1'b0;
      end
    end
  end

  // lowest corner address and corner offsets
  assign alo_d = XW'(lo_q[0]) * XW'(hw_q) + XW'(lo_q[1]) * XW'(dim_e[2]) + XW'(lo_q[2]);
  assign corner_addr = alo_q + (cnt_q[2] ? XW'(stl_q) : '0)
                             + (cnt_q[1] ? XW'(sth_q) : '0)
                             + (cnt_q[0] ? XW'(stw_q) : '0);
  assign last_addr = alo_q + XW'(stl_q) + XW'(sth_q) + XW'(stw_q);

  // axis weights of the current corner
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      w_sel[a] = cnt_q[2-a] ? {1'b0, frac_q[a]} : 9'd256 - {1'b0, frac_q[a]};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dtb_pkg::S_IDLE: begin
        if (accept) begin
          case (dtb_pkg::op_e'(opcode_i))
            dtb_pkg::OP_LOAD: state_d = dtb_pkg::S_EMIT;
            dtb_pkg::OP_TAP:  state_d = dtb_pkg::S_RANGE;
            dtb_pkg::OP_READ: state_d = dtb_pkg::S_READ;
            default:          state_d = dtb_pkg::S_EMIT;
          endcase
        end
      end
      dtb_pkg::S_READ:  state_d = dtb_pkg::S_RDATA;
      dtb_pkg::S_RDATA: state_d = dtb_pkg::S_IDLE;
      dtb_pkg::S_RANGE: state_d = dtb_pkg::S_ADDR;
      dtb_pkg::S_ADDR:  state_d = ok_q ? dtb_pkg::S_CHECK : dtb_pkg::S_EMIT;
      dtb_pkg::S_CHECK: begin
        state_d = (last_addr >= XW'(MAX_VOLUME)) ? dtb_pkg::S_EMIT : dtb_pkg::S_CORNER;
      end
      dtb_pkg::S_CORNER: if (cnt_q == 3'd7) state_d = dtb_pkg::S_DRAIN;
      dtb_pkg::S_DRAIN:  if (cnt_q == 3'd2) state_d = dtb_pkg::S_ACCUM;
      dtb_pkg::S_ACCUM:  if (cnt_q == 3'd7) state_d = dtb_pkg::S_FIN1;
      dtb_pkg::S_FIN1:   state_d = dtb_pkg::S_FIN2;
      dtb_pkg::S_FIN2:   state_d = dtb_pkg::S_IDLE;
      dtb_pkg::S_EMIT:   state_d = dtb_pkg::S_IDLE;
      default:           state_d = dtb_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cnt_d        = cnt_q;
    done_d       = 1'b0;
    ld_we        = 1'b0;
    smp_req      = '0;
    acc_req      = '0;
    acc_addr     = corner_addr[AW-1:0];
    smp_req.idx  = cnt_q;
    smp_req.wl   = w_sel[0];
    smp_req.wh   = w_sel[1];
    smp_req.ww   = w_sel[2];
    acc_req.idx  = cnt_q;
    acc_req.kind = dtb_pkg::ACC_ADD;
    case (state_q)
      dtb_pkg::S_IDLE: begin
        cnt_d = 3'd0;
        ld_we = accept && (dtb_pkg::op_e'(opcode_i) == dtb_pkg::OP_LOAD) && addr_ok;
      end
      dtb_pkg::S_READ: begin
        acc_req.vld  = rd_ok_q;
        acc_req.kind = dtb_pkg::ACC_CLR_READ;
        acc_addr     = addr_q[AW-1:0];
      end
      dtb_pkg::S_RDATA: done_d = 1'b1;
      dtb_pkg::S_CORNER: begin
        smp_req.vld = 1'b1;
        cnt_d       = (cnt_q == 3'd7) ? 3'd0 : cnt_q + 3'd1;
      end
      dtb_pkg::S_DRAIN: cnt_d = (cnt_q == 3'd2) ? 3'd0 : cnt_q + 3'd1;
      dtb_pkg::S_ACCUM: begin
        acc_req.vld = 1'b1;
        cnt_d       = cnt_q + 3'd1;
      end
      dtb_pkg::S_FIN2:  done_d = 1'b1;
      dtb_pkg::S_EMIT:  done_d = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtb_pkg::S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // item capture and tap datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q   <= addr_x;
      rd_ok_q  <= addr_ok;
      pos_q[0] <= {{2{base_l_i[6]}}, base_l_i, 8'd0} + {offset_l_i[15], offset_l_i};
      pos_q[1] <= {{2{base_h_i[6]}}, base_h_i, 8'd0} + {offset_h_i[15], offset_h_i};
      pos_q[2] <= {{2{base_w_i[6]}}, base_w_i, 8'd0} + {offset_w_i[15], offset_w_i};
      fw_q     <= filter_weight_i;
      r_q      <= residual_i;
    end
    if (state_q == dtb_pkg::S_RANGE) begin
      ok_q  <= ok_d;
      hw_q  <= dim_e[1] * dim_e[2];
      frp_q <= fw_q * r_q;
      for (int a = 0; a < 3; a++) begin
        lo_q[a]   <= pos_q[a][13:8];
        frac_q[a] <= pos_q[a][7:0];
      end
    end
    if (state_q == dtb_pkg::S_ADDR) begin
      alo_q <= alo_d;
      stl_q <= (frac_q[0] != 8'd0) ? hw_q : 12'd0;
      sth_q <= (frac_q[1] != 8'd0) ? dim_e[2] : 6'd0;
      stw_q <= (frac_q[2] != 8'd0);
    end
    if (state_q == dtb_pkg::S_FIN1) begin
      fgp_q    <= val * r_q;
      ogp_q[0] <= frp_q * diff_l;
      ogp_q[1] <= frp_q * diff_h;
      ogp_q[2] <= frp_q * diff_w;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_range_q <= 1'b0;
      fg_q       <= '0;
      ogl_q      <= '0;
      ogh_q      <= '0;
      ogw_q      <= '0;
      rdat_q     <= '0;
    end
    if (state_q == dtb_pkg::S_RDATA && rd_ok_q) begin
      rdat_q <= acc_rdata;
    end
    if (state_q == dtb_pkg::S_FIN2) begin
      in_range_q <= 1'b1;
      fg_q       <= dtb_pkg::rnd_sat(fgp_q, 5'd24);
      ogl_q      <= dtb_pkg::rnd_sat(ogp_q[0], 5'd28);
      ogh_q      <= dtb_pkg::rnd_sat(ogp_q[1], 5'd28);
      ogw_q      <= dtb_pkg::rnd_sat(ogp_q[2], 5'd28);
    end
  end

  dtb_sample_unit #(
    .MAX_VOLUME(MAX_VOLUME)
  ) u_sample (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ld_we),
    .wr_addr_i (addr_x[AW-1:0]),
    .wr_data_i (sample_value_i),
    .req_i     (smp_req),
    .rd_addr_i (corner_addr[AW-1:0]),
    .fr_prod_i (frp_q),
    .val_o     (val),
    .diff_l_o  (diff_l),
    .diff_h_o  (diff_h),
    .diff_w_o  (diff_w),
    .add_o     (add_beat)
  );

  dtb_accum_unit #(
    .MAX_VOLUME(MAX_VOLUME)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (acc_req),
    .addr_i     (acc_addr),
    .add_i      (add_beat),
    .clearing_o (clearing),
    .rdata_o    (acc_rdata)
  );

  assign done_o          = done_q;
  assign in_range_o      = in_range_q;
  assign filter_grad_o   = fg_q;
  assign offset_grad_l_o = ogl_q;
  assign offset_grad_h_o = ogh_q;
  assign offset_grad_w_o = ogw_q;
  assign read_data_o     = rdat_q;

  `DTB_ASSERT(a_done_pulse, done_q |=> !done_q, "result strobe held")
  `DTB_ASSERT(a_done_idle, done_q |-> state_q == dtb_pkg::S_IDLE, "result while busy")
  `DTB_ASSERT(a_busy_start, $rose(busy) |-> $past(start), "busy without a start")

endmodule

`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench for the deformable trilinear tap backward block
`default_nettype none

module tb_top;
  import dtb_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int VOL       = 32768;
  localparam int DIM_CAP   = 32;
  localparam int SETTLE    = 40;
  localparam int LIMIT     = 3000000;
  localparam int PHASE_LEN = 150;

  typedef struct {
    logic [1:0]         op;
    logic [14:0]        addr;
    logic signed [15:0] sample;
    logic signed [6:0]  bl, bh, bw;
    logic signed [15:0] ol, oh, ow;
    logic signed [15:0] fw, res;
  } tap_item_t;

  typedef struct packed {
    logic               in_range;
    logic signed [31:0] fg, gl, gh, gw, rd;
  } grad_t;

  typedef struct {
    tap_item_t it;
    bit        known;
    grad_t     res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done_o, cfg_ready_o;
  logic cfg_valid_i = 1'b0;
  cfg_reg_e cfg_index_i = REG_LENGTH;
  logic [5:0] cfg_data_i = '0;
  logic [1:0] opcode_i = '0;
  logic [14:0] address_i = '0;
  logic signed [15:0] sample_value_i = '0;
  logic signed [6:0] base_l_i = '0, base_h_i = '0, base_w_i = '0;
  logic signed [15:0] offset_l_i = '0, offset_h_i = '0, offset_w_i = '0;
  logic signed [15:0] filter_weight_i = '0, residual_i = '0;
  logic in_range_o;
  logic signed [31:0] filter_grad_o, offset_grad_l_o, offset_grad_h_o;
  logic signed [31:0] offset_grad_w_o, read_data_o;

  deformable_trilinear_tap_backward u_top (
    .clk_i, .rst_ni, .start, .busy, .done_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .opcode_i, .address_i, .sample_value_i,
    .base_l_i, .base_h_i, .base_w_i,
    .offset_l_i, .offset_h_i, .offset_w_i,
    .filter_weight_i, .residual_i,
    .in_range_o, .filter_grad_o, .offset_grad_l_o, .offset_grad_h_o,
    .offset_grad_w_o, .read_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow state of the block
  logic signed [15:0] sample_mem [VOL];
  bit                 sample_written [VOL];
  bit signed [31:0]   grad_mem [VOL];
  int unsigned        reg_len = 32, reg_hgt = 32, reg_wid = 32;

  grad_t grad_q[$];
  int    err_cnt = 0;
  int    cycles = 0;
  int    burst_left = 0;
  int    n_hit = 0, n_miss = 0, n_load = 0, n_read = 0, n_other = 0;

  function automatic int unsigned cap(int unsigned r);
    return r > DIM_CAP ? DIM_CAP : r;
  endfunction

  function automatic int unsigned vol_size();
    return cap(reg_len) * cap(reg_hgt) * cap(reg_wid);
  endfunction

  // round half up by n bits, saturate to 32 bits
  function automatic logic signed [31:0] round_sat(longint x, int n);
    longint y;
    y = (x + (64'sd1 <<< (n - 1))) >>> n;
    if (y > 64'sd2147483647) return 32'sh7fffffff;
    if (y < -64'sd2147483648) return 32'sh80000000;
    return y[31:0];
  endfunction

  // corner addresses and axis weights of a tap; 0 when out of range
  function automatic bit locate(tap_item_t it, output int unsigned a[8],
                                output longint w[3][2]);
    int unsigned d[3];
    longint p[3], lo[3], hi[3], fr;
    d[0] = cap(reg_len);
    d[1] = cap(reg_hgt);
    d[2] = cap(reg_wid);
    p[0] = longint'(it.bl) * 256 + longint'(it.ol);
    p[1] = longint'(it.bh) * 256 + longint'(it.oh);
    p[2] = longint'(it.bw) * 256 + longint'(it.ow);
    for (int ax = 0; ax < 3; ax++) begin
      if (d[ax] == 0 || p[ax] < 0 || p[ax] > (longint'(d[ax]) - 1) * 256) return 0;
      lo[ax] = p[ax] >>> 8;
      fr = p[ax] & 255;
      hi[ax] = (fr != 0) ? lo[ax] + 1 : lo[ax];
      w[ax][0] = 256 - fr;
      w[ax][1] = fr;
    end
    for (int i = 0; i < 8; i++) begin
      a[i] = ((i & 4) ? hi[0] : lo[0]) * d[1] * d[2]
           + ((i & 2) ? hi[1] : lo[1]) * d[2] + ((i & 1) ? hi[2] : lo[2]);
    end
    return a[7] < VOL;
  endfunction

  // expected result of one item, updating the shadow state
  function automatic grad_t tap_gradients(tap_item_t it);
    grad_t g;
    int unsigned a[8];
    longint w[3][2];
    longint c[8];
    longint val, frp, wgt, s, diff, wo;
    g = '0;
    case (it.op)
      OP_LOAD: begin
        sample_mem[it.addr] = it.sample;
        sample_written[it.addr] = 1'b1;
        n_load++;
      end
      OP_READ: begin
        g.rd = grad_mem[it.addr];
        grad_mem[it.addr] = 0;
        n_read++;
      end
      OP_TAP: begin
        if (!locate(it, a, w)) begin
          n_miss++;
        end else begin
          n_hit++;
          frp = longint'(it.fw) * longint'(it.res);
          val = 0;
          for (int i = 0; i < 8; i++) begin
            c[i] = sample_mem[a[i]];
            val += c[i] * w[0][(i >> 2) & 1] * w[1][(i >> 1) & 1] * w[2][i & 1];
          end
          // scatter-add, saturating after each corner
          for (int i = 0; i < 8; i++) begin
            wgt = w[0][(i >> 2) & 1] * w[1][(i >> 1) & 1] * w[2][i & 1];
            s = longint'(grad_mem[a[i]]) + longint'(round_sat(frp * wgt, 24));
            if (s > 64'sd2147483647) s = 64'sd2147483647;
            if (s < -64'sd2147483648) s = -64'sd2147483648;
            grad_mem[a[i]] = s[31:0];
          end
          g.in_range = 1'b1;
          g.fg = round_sat(val * longint'(it.res), 24);
          for (int ax = 0; ax < 3; ax++) begin
            diff = 0;
            for (int i = 0; i < 8; i++) begin
              wo = 1;
              for (int b = 0; b < 3; b++)
                if (b != ax) wo *= w[b][(i >> (2 - b)) & 1];
              if ((i >> (2 - ax)) & 1) diff += c[i] * wo;
              else diff -= c[i] * wo;
            end
            case (ax)
              0: g.gl = round_sat(frp * diff, 28);
              1: g.gh = round_sat(frp * diff, 28);
              default: g.gw = round_sat(frp * diff, 28);
            endcase
          end
        end
      end
      default: n_other++;
    endcase
    return g;
  endfunction

  function automatic tap_item_t mk(logic [1:0] op, int addr, int smp, int bl, int bh,
                                   int bw, int ol, int oh, int ow, int fw, int res);
    tap_item_t it;
    it.op = op;
    it.addr = addr[14:0];
    it.sample = smp[15:0];
    it.bl = bl[6:0];
    it.bh = bh[6:0];
    it.bw = bw[6:0];
    it.ol = ol[15:0];
    it.oh = oh[15:0];
    it.ow = ow[15:0];
    it.fw = fw[15:0];
    it.res = res[15:0];
    return it;
  endfunction

  // one item beat, with the sender's burst and gap pattern after it
  task automatic send_one(tap_item_t it, bit known, grad_t res);
    grad_t p;
    start <= 1'b1;
    opcode_i <= it.op;
    address_i <= it.addr;
    sample_value_i <= it.sample;
    base_l_i <= it.bl;
    base_h_i <= it.bh;
    base_w_i <= it.bw;
    offset_l_i <= it.ol;
    offset_h_i <= it.oh;
    offset_w_i <= it.ow;
    filter_weight_i <= it.fw;
    residual_i <= it.res;
    do @(posedge clk_i); while (busy);
    p = tap_gradients(it);
    grad_q.push_back(known ? res : p);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // load any unwritten corner first so no tap reads an empty sample
  task automatic send(tap_item_t it, bit known, grad_t res);
    int unsigned a[8];
    longint w[3][2];
    grad_t none;
    none = '0;
    if (it.op == OP_TAP && locate(it, a, w)) begin
      for (int i = 0; i < 8; i++)
        if (!sample_written[a[i]])
          send_one(mk(OP_LOAD, a[i], $urandom, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);
    end
    send_one(it, known, res);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk_i);
    while (grad_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [5:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_LENGTH: reg_len = v;
      REG_HEIGHT: reg_hgt = v;
      default:    reg_wid = v;
    endcase
  endtask

  task automatic set_dims(logic [5:0] l, logic [5:0] h, logic [5:0] w);
    quiesce();
    write_reg(REG_LENGTH, l);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
  endtask

  function automatic tap_item_t rand_item();
    tap_item_t it;
    int kind;
    int unsigned sz, d[3];
    longint p[3], bs[3];
    it = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom);
    sz = vol_size();
    d[0] = cap(reg_len);
    d[1] = cap(reg_hgt);
    d[2] = cap(reg_wid);
    kind = $urandom_range(0, 99);
    if (kind < 50 && sz != 0) begin
      // well-formed tap inside the volume, some on whole grid points
      it.op = OP_TAP;
      for (int ax = 0; ax < 3; ax++) begin
        p[ax] = $urandom_range(0, (d[ax] - 1) * 256);
        if ($urandom_range(0, 3) == 0) p[ax] = p[ax] & ~longint'(255);
        bs[ax] = longint'($urandom_range(0, 127)) - 64;
      end
      it.bl = bs[0][6:0];
      it.bh = bs[1][6:0];
      it.bw = bs[2][6:0];
      it.ol = 16'(p[0] - bs[0] * 256);
      it.oh = 16'(p[1] - bs[1] * 256);
      it.ow = 16'(p[2] - bs[2] * 256);
    end else if (kind < 58) begin
      it.op = OP_TAP;
    end else if (kind < 76) begin
      it.op = OP_LOAD;
      if (sz != 0 && $urandom_range(0, 3) != 0) it.addr = $urandom_range(0, sz - 1);
    end else if (kind < 96) begin
      it.op = OP_READ;
      if (sz != 0 && $urandom_range(0, 3) != 0) it.addr = $urandom_range(0, sz - 1);
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // result checker, one beat per done strobe
  always @(posedge clk_i) begin
    grad_t got, want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_ni && done_o) begin
      got = '{in_range_o, filter_grad_o, offset_grad_l_o, offset_grad_h_o,
              offset_grad_w_o, read_data_o};
      if (grad_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result beat at cycle %0d", cycles);
      end else begin
        want = grad_q.pop_front();
        if (got.in_range !== want.in_range || got.fg !== want.fg || got.gl !== want.gl ||
            got.gh !== want.gh || got.gw !== want.gw || got.rd !== want.rd) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch at cycle %0d", cycles);
            $display("  in_range exp %0d got %0d, filter_grad exp %0d got %0d",
                     want.in_range, got.in_range, want.fg, got.fg);
            $display("  offset_grad l/h/w exp %0d %0d %0d got %0d %0d %0d",
                     want.gl, want.gh, want.gw, got.gl, got.gh, got.gw);
            $display("  read_data exp %0d got %0d", want.rd, got.rd);
          end
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    grad_t zero;
    zero = '0;
    // directed: reset reads, extremes, range edges, unused opcode
    rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero});
    rows.push_back('{mk(OP_READ, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero});
    rows.push_back('{mk(OP_UNUSED, 32767, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1, zero});
    rows.push_back('{mk(OP_TAP, 0, 0, -64, -64, -64, -32768, -32768, -32768,
                        32767, 32767), 1, zero});
    rows.push_back('{mk(OP_TAP, 0, 0, 63, 63, 63, 32767, 32767, 32767,
                        -32768, -32768), 1, zero});
    rows.push_back('{mk(OP_TAP, 0, 0, 31, 31, 31, 1, 1, 1, 4096, 4096), 1, zero});
    rows.push_back('{mk(OP_TAP, 0, 0, 0, 0, 0, -1, 0, 0, 4096, 4096), 1, zero});
    rows.push_back('{mk(OP_LOAD, 0, -32768, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero});
    rows.push_back('{mk(OP_LOAD, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero});
    rows.push_back('{mk(OP_TAP, 0, 0, 0, 0, 0, 0, 0, 0, -32768, -32768), 0, zero});
    rows.push_back('{mk(OP_TAP, 0, 0, 31, 31, 31, 0, 0, 0, 32767, 32767), 0, zero});
    rows.push_back('{mk(OP_TAP, 0, 0, 0, 0, 0, 128, 128, 128, 32767, -32768), 0, zero});
    rows.push_back('{mk(OP_TAP, 0, 0, 1, 1, 1, -256, -255, -1, -32768, 32767), 0, zero});
    rows.push_back('{mk(OP_TAP, 0, 0, -64, 63, 10, 16384, -16128, 77, 12345, -777), 0, zero});
    rows.push_back('{mk(OP_TAP, 0, 0, 30, 30, 30, 255, 255, 255, -32768, -32768), 0, zero});
    rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero});
    rows.push_back('{mk(OP_READ, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero});
    rows.push_back('{mk(OP_READ, 1057, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, zero});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) send(rows[i].it, rows[i].known, rows[i].res);

    // random phases over several volume shapes, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: set_dims(6'd1, 6'd1, 6'd1);
        2: set_dims(6'd63, 6'd63, 6'd63);
        3: set_dims(6'd0, 6'd5, 6'd7);
        4: set_dims(6'd3, 6'd4, 6'd5);
        5: set_dims(6'd32, 6'd1, 6'd32);
        6: set_dims($urandom_range(1, 63), $urandom_range(1, 63), $urandom_range(1, 63));
        7: set_dims(6'd2, 6'd2, 6'd2);
        default: ;
      endcase
      repeat (PHASE_LEN) send(rand_item(), 1'b0, zero);
    end

    quiesce();
    $display("covered %0d taps in range, %0d out of range, %0d loads, %0d readouts, %0d unused",
             n_hit, n_miss, n_load, n_read, n_other);
    $display("over eight volume shapes, with %0d failures", err_cnt);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
